@@ rtl/core/shash_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package shash_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  // byte source codes for the block window
  localparam logic [1:0] BSEL_IN   = 2'd0;
  localparam logic [1:0] BSEL_PAD  = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  localparam logic [WordW-1:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       push;       // shift one byte into the block window
    logic [1:0] bsel;       // byte source
    logic       cnt_byte;   // count a message byte in the bit length
    logic       cap_len;    // capture the bit length for padding
    logic       init_vars;  // load a..h from the chained hash
    logic       round;      // run one compression round
    logic [5:0] rnd;        // round number
    logic       add_hash;   // fold a..h into the chained hash
    logic       restart;    // back to initial values
    logic [2:0] widx;       // digest word select
  } shash_cmd_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha256_stream_hasher.sv @@
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_stall    in_kind, in_data_byte
// out_      result     out_valid / out_stall  out_digest_word, out_word_index, out_last_word
//
// Data bytes are taken one per cycle while in_stall is low; every 64th byte starts
// the compression (one load step, 64 rounds through the single round unit, one hash add).
// A finish request captures the bit length, then pads one byte per cycle (pausing for any
// compression) up to the block end, with an idle step before the eight length bytes, runs
// one or two compressions, then presents the eight digest words, one per unstalled cycle.
// Reset (rst_n low, synchronous) restores the initial hash and empties the block.
// in_stall is high whenever the block is busy; out_stall holds the current word.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher import shash_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  shash_cmd_t cmd;

  // sequence the byte loads, padding, rounds and word output
  shash_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (out_word_index),
    .last_word  (out_last_word),
    .cmd        (cmd)
  );

  // hold the block window, working variables and chained hash
  shash_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_data_byte),
    .digest_word (out_digest_word)
  );

endmodule
`default_nettype wire

@@ rtl/core/shash_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module shash_dp import shash_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire shash_cmd_t       cmd,
  input  wire logic [7:0]       in_byte,
  output logic      [WordW-1:0] digest_word
);

  logic [WordW-1:0] w_r   [16];
  logic [WordW-1:0] w_nxt [16];
  logic [WordW-1:0] h_r   [8];
  logic [WordW-1:0] v_r   [8];
  logic [63:0]      bits_r;
  logic [63:0]      len_r;
  logic [7:0]       byte_sel;
  logic [WordW-1:0] w_new, t1, t2;
  logic [WordW-1:0] a, b, c, e, f, g;

  assign a = v_r[0];
  assign b = v_r[1];
  assign c = v_r[2];
  assign e = v_r[4];
  assign f = v_r[5];
  assign g = v_r[6];

  always_comb begin
    case (cmd.bsel)
      BSEL_IN:   byte_sel = in_byte;
      BSEL_PAD:  byte_sel = 8'h80;
      BSEL_ZERO: byte_sel = 8'h00;
      BSEL_LEN:  byte_sel = len_r[63:56];
      default:   byte_sel = 8'h00;
    endcase
  end

  assign w_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
               + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];

  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[cmd.rnd] + w_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      w_nxt[j] = w_r[j];
    end
    if (cmd.push) begin
      for (int j = 0; j < 15; j++) begin
        w_nxt[j] = {w_r[j][23:0], w_r[j+1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], byte_sel};
    end else if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w_nxt[j] = w_r[j+1];
      end
      w_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) begin
      w_r[j] <= w_nxt[j];
    end
    if (cmd.init_vars) begin
      for (int j = 0; j < 8; j++) begin
        v_r[j] <= h_r[j];
      end
    end else if (cmd.round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= a;
      v_r[2] <= b;
      v_r[3] <= c;
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= e;
      v_r[6] <= f;
      v_r[7] <= g;
    end
    if (cmd.cap_len) begin
      len_r <= bits_r;
    end else if (cmd.push && cmd.bsel == BSEL_LEN) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int j = 0; j < 8; j++) begin
        h_r[j] <= INIT_H[j];
      end
      bits_r <= '0;
    end else begin
      if (cmd.add_hash) begin
        for (int j = 0; j < 8; j++) begin
          h_r[j] <= h_r[j] + v_r[j];
        end
      end
      if (cmd.cnt_byte) begin
        bits_r <= bits_r + 64'd8;
      end
    end
  end

  assign digest_word = h_r[cmd.widx];

endmodule
`default_nettype wire

@@ rtl/core/shash_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module shash_ctrl import shash_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_kind,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      word_index,
  output logic            last_word,
  output shash_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_PADZ   = 3'd2;
  localparam logic [2:0] S_PADLEN = 3'd3;
  localparam logic [2:0] S_INIT   = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign word_index = cnt_r;
  assign last_word  = (cnt_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;
    cmd.widx  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_kind) begin
          cmd.push     = 1'b1;
          cmd.bsel     = BSEL_IN;
          cmd.cnt_byte = 1'b1;
        end else if (in_valid) begin
          cmd.cap_len = 1'b1;
          state_nxt   = S_PAD80;
        end
        ret_nxt = S_IDLE;
      end
      S_PAD80: begin
        cmd.push  = 1'b1;
        cmd.bsel  = BSEL_PAD;
        state_nxt = S_PADZ;
        ret_nxt   = S_PADZ;
      end
      S_PADZ: begin
        if (fill_r == 6'd56) begin
          state_nxt = S_PADLEN;
          cnt_nxt   = '0;
        end else begin
          cmd.push = 1'b1;
          cmd.bsel = BSEL_ZERO;
        end
        ret_nxt = S_PADZ;
      end
      S_PADLEN: begin
        cmd.push = 1'b1;
        cmd.bsel = BSEL_LEN;
        cnt_nxt  = cnt_r + 3'd1;
        ret_nxt  = S_OUT;
      end
      S_INIT: begin
        cmd.init_vars = 1'b1;
        rnd_nxt       = '0;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        state_nxt    = ret_r;
      end
      S_OUT: begin
        if (!out_stall) begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            cmd.restart = 1'b1;
            fill_nxt    = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a full window starts the compression
    if (cmd.push) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        state_nxt = S_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      fill_r  <= '0;
      rnd_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_last_round_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> state_r == S_ADD)
    else $error("last round not followed by hash add");

  a_len_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PADLEN) |-> fill_r >= 6'd56)
    else $error("length bytes outside block tail");

  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> fill_r == 6'd0)
    else $error("digest emitted with partial block");

endmodule
`default_nettype wire
